/* design/abhcc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abhcc_pkg
// Shared widths, register indexes and fixed constants of the adaptive blue
// hue contour check.
// ----------------------------------------------------------------------------
package abhcc_pkg;

   // Field widths of the point and result beats.
   localparam int HUE_W   = 8;
   localparam int SAT_W   = 8;
   localparam int RATIO_W = 7;
   localparam int COUNT_W = 11;
   localparam int HALF_W  = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_SAT_MIN       = 3'd0;
   localparam csr_idx_type REG_RATIO_PERCENT = 3'd1;
   localparam csr_idx_type REG_LOW_FLOOR     = 3'd2;
   localparam csr_idx_type REG_LOW_CEIL      = 3'd3;
   localparam csr_idx_type REG_HIGH_FLOOR    = 3'd4;
   localparam csr_idx_type REG_HIGH_CEIL     = 3'd5;
   localparam csr_idx_type REG_NEAR_MARGIN   = 3'd6;
   localparam csr_idx_type REG_FAR_MARGIN    = 3'd7;

   // Register reset values.
   localparam logic [SAT_W-1:0]   SAT_MIN_RST       = 8'd100;
   localparam logic [RATIO_W-1:0] RATIO_PERCENT_RST = 7'd12;
   localparam logic [HUE_W-1:0]   LOW_FLOOR_RST     = 8'd100;
   localparam logic [HUE_W-1:0]   LOW_CEIL_RST      = 8'd140;
   localparam logic [HUE_W-1:0]   HIGH_FLOOR_RST    = 8'd160;
   localparam logic [HUE_W-1:0]   HIGH_CEIL_RST     = 8'd200;
   localparam logic [HUE_W-1:0]   NEAR_MARGIN_RST   = 8'd5;
   localparam logic [HUE_W-1:0]   FAR_MARGIN_RST    = 8'd10;

   // Hue limits after reset.
   localparam logic [HUE_W-1:0] LOW_LIMIT_RST  = 8'd120;
   localparam logic [HUE_W-1:0] HIGH_LIMIT_RST = 8'd180;

   // A contour must have more than this many blue points to adapt the limits.
   localparam int BLUE_MIN_COUNT = 5;
   // Percent scale and the over-half threshold (floored percent above 50).
   localparam int PERCENT_SCALE = 100;
   localparam int HALF_PERCENT  = 50;

endpackage

`default_nettype wire

/* design/abhcc_channels.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abhcc channels
// Valid/ready interfaces for contour points, contour results and register
// writes.
// ----------------------------------------------------------------------------

interface abhcc_req_if;
   logic                           valid;
   logic                           ready;
   logic [abhcc_pkg::HUE_W-1:0]    hue;
   logic [abhcc_pkg::SAT_W-1:0]    sat;
   logic                           last_point;

   modport source (output valid, output hue, output sat, output last_point, input ready);
   modport sink   (input valid, input hue, input sat, input last_point, output ready);
endinterface

interface abhcc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           is_blue;
   logic                           over_half;
   logic [abhcc_pkg::COUNT_W-1:0]  blue_points;
   logic [abhcc_pkg::COUNT_W-1:0]  point_total;
   logic [abhcc_pkg::HALF_W-1:0]   over_half_contours;
   logic [abhcc_pkg::HUE_W-1:0]    low_hue_out;
   logic [abhcc_pkg::HUE_W-1:0]    high_hue_out;

   modport source (output valid, output is_blue, output over_half, output blue_points,
                   output point_total, output over_half_contours, output low_hue_out,
                   output high_hue_out, input ready);
   modport sink   (input valid, input is_blue, input over_half, input blue_points,
                   input point_total, input over_half_contours, input low_hue_out,
                   input high_hue_out, output ready);
endinterface

interface abhcc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [abhcc_pkg::CSR_IDX_W-1:0]   index;
   logic [abhcc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/adaptive_blue_hue_contour_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_blue_hue_contour_check
// Classifies contours as blue from per-point hue and saturation and adapts
// the blue hue window from contour to contour.
// ----------------------------------------------------------------------------
// Usage:
// Contour points arrive on req_chan, one point per beat, with last_point set
// on the final point of a contour. Every point is taken in its own cycle;
// points that do not close a contour produce no result. The closing point
// produces one result beat on rsp_chan with the blue verdict, the counts,
// the saturating over-half count and the hue limits after adaptation.
// Registers are written on csr_chan, one beat per register; the user must
// write them only while the block is idle, which the block itself does not
// enforce; csr_chan is always ready. Flow: a point is registered in stage 1
// at acceptance and is then folded into the contour state; for a closing
// point the contour snapshot is registered in stage 2 and then moves into
// the output stage as the result beat. Throughput is one point per cycle
// while no closing point is held back by a stalled result side.
// Reset (synchronous) restores register defaults, hue limits 120 and 180,
// clears all counts and empties the pipeline. When the receiver stalls, the
// result and snapshot stages hold; ordinary points keep flowing until a
// closing point finds both stages occupied, then req_chan.ready drops.
// ----------------------------------------------------------------------------
module adaptive_blue_hue_contour_check #(
   parameter int MAX_POINTS = 1024,
   parameter int HUE_STEP   = 1
) (
   input  wire logic  clock,
   input  wire logic  reset,
   abhcc_req_if.sink   req_chan,
   abhcc_rsp_if.source rsp_chan,
   abhcc_csr_if.sink   csr_chan
);

   // Counter width: enough to hold MAX_POINTS itself.
   localparam int CW     = $clog2(MAX_POINTS + 1);
   // Product width for count times a percent value below 128.
   localparam int PW     = CW + 7;
   // Width used to zero-extend a count before masking it to the output field.
   localparam int CW_EXT = (CW > abhcc_pkg::COUNT_W) ? CW : abhcc_pkg::COUNT_W;
   localparam int HW     = abhcc_pkg::HUE_W;

   localparam logic [HW-1:0] STEP8 = HW'(HUE_STEP);
   localparam logic [HW:0]   STEP9 = (HW+1)'(HUE_STEP);

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic [abhcc_pkg::SAT_W-1:0]   sat_min_ff;
   logic [abhcc_pkg::RATIO_W-1:0] ratio_ff;
   logic [HW-1:0]                 low_floor_ff, low_ceil_ff, high_floor_ff, high_ceil_ff;
   logic [HW-1:0]                 near_ff, far_ff;
   logic                          csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_min_ff    <= abhcc_pkg::SAT_MIN_RST;
         ratio_ff      <= abhcc_pkg::RATIO_PERCENT_RST;
         low_floor_ff  <= abhcc_pkg::LOW_FLOOR_RST;
         low_ceil_ff   <= abhcc_pkg::LOW_CEIL_RST;
         high_floor_ff <= abhcc_pkg::HIGH_FLOOR_RST;
         high_ceil_ff  <= abhcc_pkg::HIGH_CEIL_RST;
         near_ff       <= abhcc_pkg::NEAR_MARGIN_RST;
         far_ff        <= abhcc_pkg::FAR_MARGIN_RST;
      end else if (csr_write) begin
         unique case (csr_chan.index)
            abhcc_pkg::REG_SAT_MIN:       sat_min_ff    <= csr_chan.data;
            abhcc_pkg::REG_RATIO_PERCENT: ratio_ff      <= csr_chan.data[abhcc_pkg::RATIO_W-1:0];
            abhcc_pkg::REG_LOW_FLOOR:     low_floor_ff  <= csr_chan.data;
            abhcc_pkg::REG_LOW_CEIL:      low_ceil_ff   <= csr_chan.data;
            abhcc_pkg::REG_HIGH_FLOOR:    high_floor_ff <= csr_chan.data;
            abhcc_pkg::REG_HIGH_CEIL:     high_ceil_ff  <= csr_chan.data;
            abhcc_pkg::REG_NEAR_MARGIN:   near_ff       <= csr_chan.data;
            abhcc_pkg::REG_FAR_MARGIN:    far_ff        <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline handshakes. Stage 1 holds the accepted point. Stage 2 holds the
   // snapshot of a closed contour. The output stage holds the result beat.
   // ------------------------------------------------------------------------
   logic          s1_valid_ff;
   logic [HW-1:0] s1_hue_ff;
   logic [abhcc_pkg::SAT_W-1:0] s1_sat_ff;
   logic          s1_last_ff;

   logic          s2_valid_ff;
   logic [CW-1:0] s2_blue_ff, s2_total_ff;
   logic [HW-1:0] s2_low_ff, s2_high_ff;

   logic          out_valid_ff;

   logic move1, move2, req_accept;

   assign move2      = s2_valid_ff && (!out_valid_ff || rsp_chan.ready);
   // Ordinary points never need the snapshot slot.
   assign move1      = s1_valid_ff && (!s1_last_ff || !s2_valid_ff || move2);
   assign req_chan.ready = !s1_valid_ff || move1;
   assign req_accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_hue_ff  <= req_chan.hue;
         s1_sat_ff  <= req_chan.sat;
         s1_last_ff <= req_chan.last_point;
      end
   end

   // ------------------------------------------------------------------------
   // Contour state: tallies, running blue hue window and the hue limits.
   // ------------------------------------------------------------------------
   logic [CW-1:0] blue_tally_ff, point_tally_ff;
   logic [HW-1:0] run_min_ff, run_max_ff;
   logic [HW-1:0] low_limit_ff, high_limit_ff;

   logic [CW-1:0] blue_nx, total_nx;
   logic [HW-1:0] run_min_nx, run_max_nx;
   logic          counted, point_blue;
   logic [HW-1:0] mn_a, mn, mx_a, mx;
   logic [HW:0]   lo_up, hi_up;
   logic [HW-1:0] lo_a, lo_b, hi_a, hi_b;
   logic          adapt;

   always_comb begin
      counted    = point_tally_ff < CW'(MAX_POINTS);
      point_blue = (s1_sat_ff > sat_min_ff) && (s1_hue_ff < high_limit_ff)
                   && (s1_hue_ff > low_limit_ff);

      blue_nx    = blue_tally_ff;
      total_nx   = point_tally_ff;
      run_min_nx = run_min_ff;
      run_max_nx = run_max_ff;
      if (counted) begin
         total_nx = point_tally_ff + CW'(1);
         if (point_blue) begin
            blue_nx = blue_tally_ff + CW'(1);
            if (s1_hue_ff > run_max_ff) run_max_nx = s1_hue_ff;
            if (s1_hue_ff < run_min_ff) run_min_nx = s1_hue_ff;
         end
      end

      // Clamp the observed window: floor then ceiling for the minimum,
      // ceiling then floor for the maximum.
      mn_a = (run_min_nx > low_floor_ff) ? run_min_nx : low_floor_ff;
      mn   = (mn_a < low_ceil_ff) ? mn_a : low_ceil_ff;
      mx_a = (run_max_nx < high_ceil_ff) ? run_max_nx : high_ceil_ff;
      mx   = (mx_a > high_floor_ff) ? mx_a : high_floor_ff;

      // Lower limit: move up when the minimum sits well above it, then move
      // down when the minimum comes close to the (possibly raised) limit.
      lo_a = low_limit_ff;
      if ({1'b0, mn} > ({1'b0, low_limit_ff} + {1'b0, far_ff})) begin
         lo_up = {1'b0, low_limit_ff} + STEP9;
         lo_a  = lo_up[HW] ? {HW{1'b1}} : lo_up[HW-1:0];
      end else begin
         lo_up = '0;
      end
      lo_b = lo_a;
      if ({1'b0, mn} < ({1'b0, lo_a} + {1'b0, near_ff})) begin
         lo_b = (lo_a < STEP8) ? '0 : lo_a - STEP8;
      end

      // Upper limit mirrors the lower one. The compares are rearranged so
      // that nothing goes negative.
      hi_a = high_limit_ff;
      if (({1'b0, mx} + {1'b0, far_ff}) < {1'b0, high_limit_ff}) begin
         hi_a = (high_limit_ff < STEP8) ? '0 : high_limit_ff - STEP8;
      end
      hi_b = hi_a;
      if (({1'b0, mx} + {1'b0, near_ff}) > {1'b0, hi_a}) begin
         hi_up = {1'b0, hi_a} + STEP9;
         hi_b  = hi_up[HW] ? {HW{1'b1}} : hi_up[HW-1:0];
      end else begin
         hi_up = '0;
      end

      adapt = blue_nx > CW'(abhcc_pkg::BLUE_MIN_COUNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blue_tally_ff  <= '0;
         point_tally_ff <= '0;
         run_min_ff     <= abhcc_pkg::LOW_CEIL_RST;
         run_max_ff     <= abhcc_pkg::HIGH_FLOOR_RST;
         low_limit_ff   <= abhcc_pkg::LOW_LIMIT_RST;
         high_limit_ff  <= abhcc_pkg::HIGH_LIMIT_RST;
      end else if (move1) begin
         if (s1_last_ff) begin
            // Close the contour and reseed from the current clamp settings.
            blue_tally_ff  <= '0;
            point_tally_ff <= '0;
            run_min_ff     <= low_ceil_ff;
            run_max_ff     <= high_floor_ff;
            if (adapt) begin
               low_limit_ff  <= lo_b;
               high_limit_ff <= hi_b;
            end
         end else begin
            blue_tally_ff  <= blue_nx;
            point_tally_ff <= total_nx;
            run_min_ff     <= run_min_nx;
            run_max_ff     <= run_max_nx;
         end
      end
   end

   // Snapshot of a closed contour.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (move1 && s1_last_ff) begin
         s2_valid_ff <= 1'b1;
      end else if (move2) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move1 && s1_last_ff) begin
         s2_blue_ff  <= blue_nx;
         s2_total_ff <= total_nx;
         s2_low_ff   <= adapt ? lo_b : low_limit_ff;
         s2_high_ff  <= adapt ? hi_b : high_limit_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Result stage: exact percent compares and the over-half count.
   // floor(100*blue/total) > 50 is the same as 100*blue >= 51*total.
   // ------------------------------------------------------------------------
   logic [PW-1:0] blue_scaled, ratio_scaled, half_scaled;
   logic          is_blue_nx, over_half_nx;
   logic [abhcc_pkg::HALF_W-1:0] half_tally_ff, half_tally_nx;

   logic                          out_is_blue_ff, out_over_half_ff;
   logic [abhcc_pkg::COUNT_W-1:0] out_blue_ff, out_total_ff;
   logic [HW-1:0]                 out_low_ff, out_high_ff;

   always_comb begin
      blue_scaled  = PW'(s2_blue_ff) * PW'(abhcc_pkg::PERCENT_SCALE);
      ratio_scaled = PW'(ratio_ff) * PW'(s2_total_ff);
      half_scaled  = PW'(s2_total_ff) * PW'(abhcc_pkg::HALF_PERCENT + 1);
      is_blue_nx   = blue_scaled > ratio_scaled;
      over_half_nx = blue_scaled >= half_scaled;
      half_tally_nx = half_tally_ff;
      if (over_half_nx && (half_tally_ff != {abhcc_pkg::HALF_W{1'b1}})) begin
         half_tally_nx = half_tally_ff + abhcc_pkg::HALF_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         half_tally_ff <= '0;
      end else begin
         if (move2) begin
            out_valid_ff  <= 1'b1;
            half_tally_ff <= half_tally_nx;
         end else if (rsp_chan.ready) begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move2) begin
         out_is_blue_ff   <= is_blue_nx;
         out_over_half_ff <= over_half_nx;
         out_blue_ff      <= abhcc_pkg::COUNT_W'(CW_EXT'(s2_blue_ff));
         out_total_ff     <= abhcc_pkg::COUNT_W'(CW_EXT'(s2_total_ff));
         out_low_ff       <= s2_low_ff;
         out_high_ff      <= s2_high_ff;
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.is_blue            = out_is_blue_ff;
   assign rsp_chan.over_half          = out_over_half_ff;
   assign rsp_chan.blue_points        = out_blue_ff;
   assign rsp_chan.point_total        = out_total_ff;
   assign rsp_chan.over_half_contours = half_tally_ff;
   assign rsp_chan.low_hue_out        = out_low_ff;
   assign rsp_chan.high_hue_out       = out_high_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_blue_le_total: assert property (@(posedge clock) disable iff (reset)
      blue_tally_ff <= point_tally_ff)
      else $error("blue tally exceeds point tally");

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      point_tally_ff <= CW'(MAX_POINTS))
      else $error("point tally beyond MAX_POINTS");

   a_limits_hold: assert property (@(posedge clock) disable iff (reset)
      !(move1 && s1_last_ff) |=> $stable(low_limit_ff) && $stable(high_limit_ff))
      else $error("hue limits moved without a closing point");

   a_half_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> half_tally_ff >= $past(half_tally_ff))
      else $error("over-half count decreased");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !s2_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Adaptive blue hue contour check testbench
// Streams contour points into the block, predicts each contour verdict with
// an in-bench model of the hue window logic, and compares every result beat
// field by field. The run covers directed boundary contours, threshold
// extremes, the over-half count, widening of the hue limits, randomized
// traffic with idling on both sides, and a long receiver stall that backs
// the pipeline up into the point input.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Block parameters, passed explicitly so the predictor and the block agree.
   localparam int MAX_POINTS = 1024;
   localparam int HUE_STEP   = 1;

   // Points that close nothing may still be in flight when the last result
   // arrives, so idle periods also wait out SETTLE_CYCLES after it.
   localparam int SETTLE_CYCLES  = 8;
   localparam int HALF_COUNT_MAX = 65535;
   localparam int HUE_MAX        = 255;

   // Hard stop for the whole run. The slowest legal run is well under a
   // millisecond of simulated time; this leaves a wide margin.
   localparam int LIMIT_NS = 10_000_000;

   // Expected contents of one result beat.
   typedef struct packed {
      logic                          is_blue;
      logic                          over_half;
      logic [abhcc_pkg::COUNT_W-1:0] blue_points;
      logic [abhcc_pkg::COUNT_W-1:0] point_total;
      logic [abhcc_pkg::HALF_W-1:0]  over_half_contours;
      logic [abhcc_pkg::HUE_W-1:0]   low_hue_out;
      logic [abhcc_pkg::HUE_W-1:0]   high_hue_out;
   } contour_verdict_type;

   logic clock = 1'b0;
   logic reset;

   abhcc_req_if point_if ();
   abhcc_rsp_if verdict_if ();
   abhcc_csr_if csr_if ();

   adaptive_blue_hue_contour_check #(
      .MAX_POINTS(MAX_POINTS),
      .HUE_STEP  (HUE_STEP)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(point_if),
      .rsp_chan(verdict_if),
      .csr_chan(csr_if)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predictor state: a copy of the register file as written so far and of
   // the per-contour tracking that the block keeps.
   // -------------------------------------------------------------------------
   logic [abhcc_pkg::SAT_W-1:0]   sat_min_cfg;
   logic [abhcc_pkg::RATIO_W-1:0] ratio_cfg;
   logic [abhcc_pkg::HUE_W-1:0]   low_floor_cfg;
   logic [abhcc_pkg::HUE_W-1:0]   low_ceil_cfg;
   logic [abhcc_pkg::HUE_W-1:0]   high_floor_cfg;
   logic [abhcc_pkg::HUE_W-1:0]   high_ceil_cfg;
   logic [abhcc_pkg::HUE_W-1:0]   near_margin_cfg;
   logic [abhcc_pkg::HUE_W-1:0]   far_margin_cfg;

   logic [abhcc_pkg::HUE_W-1:0]   low_limit;
   logic [abhcc_pkg::HUE_W-1:0]   high_limit;
   logic [abhcc_pkg::HUE_W-1:0]   min_blue_hue;
   logic [abhcc_pkg::HUE_W-1:0]   max_blue_hue;
   logic [abhcc_pkg::COUNT_W-1:0] blue_count;
   logic [abhcc_pkg::COUNT_W-1:0] point_count;
   logic [abhcc_pkg::HALF_W-1:0]  half_blue_contours;

   // Verdicts predicted for accepted closing points, oldest first.
   contour_verdict_type awaited_verdicts[$];

   int error_count = 0;
   int verdicts_seen = 0;

   // Idle percentages for the point sender and the result receiver.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // When nonzero, the receiver keeps ready low and counts this value down.
   int backpressure_cycles = 0;

   task automatic flag_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         flag_error($sformatf("verdict %0d, %s: got %0d, expected %0d",
                              verdicts_seen, name, got, want));
      end
   endtask

   function automatic int clamp_hue(input int value);
      if (value < 0) return 0;
      if (value > HUE_MAX) return HUE_MAX;
      return value;
   endfunction

   // -------------------------------------------------------------------------
   // Fold one accepted point into the predicted contour state. A closing
   // point adapts the hue window, produces the expected verdict, and reseeds
   // the running minimum and maximum from the clamp registers as they stand
   // now. A register write in mid contour would therefore not reseed them.
   // -------------------------------------------------------------------------
   task automatic fold_point(input logic [abhcc_pkg::HUE_W-1:0] hue,
                             input logic [abhcc_pkg::SAT_W-1:0] sat,
                             input logic last_point);
      contour_verdict_type verdict;
      int blue;
      int total;
      int min_hue;
      int max_hue;
      int lo;
      int hi;
      logic over_half;

      // Points past the size cap are dropped, but a closing point still closes.
      if (point_count < MAX_POINTS) begin
         point_count++;
         if (sat > sat_min_cfg && hue < high_limit && hue > low_limit) begin
            if (hue > max_blue_hue) max_blue_hue = hue;
            if (hue < min_blue_hue) min_blue_hue = hue;
            blue_count++;
         end
      end
      if (last_point) begin
         blue  = int'(blue_count);
         total = int'(point_count);
         if (blue > abhcc_pkg::BLUE_MIN_COUNT) begin
            // The maximum takes its ceiling first, the minimum its floor first.
            max_hue = (max_blue_hue < high_ceil_cfg) ? int'(max_blue_hue)
                                                     : int'(high_ceil_cfg);
            if (max_hue < int'(high_floor_cfg)) max_hue = int'(high_floor_cfg);
            min_hue = (min_blue_hue > low_floor_cfg) ? int'(min_blue_hue)
                                                     : int'(low_floor_cfg);
            if (min_hue > int'(low_ceil_cfg)) min_hue = int'(low_ceil_cfg);
            lo = int'(low_limit);
            hi = int'(high_limit);
            // The second compare of each pair sees the result of the first.
            if (min_hue > lo + int'(far_margin_cfg)) lo = clamp_hue(lo + HUE_STEP);
            if (min_hue < lo + int'(near_margin_cfg)) lo = clamp_hue(lo - HUE_STEP);
            if (max_hue < hi - int'(far_margin_cfg)) hi = clamp_hue(hi - HUE_STEP);
            if (max_hue > hi - int'(near_margin_cfg)) hi = clamp_hue(hi + HUE_STEP);
            low_limit  = lo[abhcc_pkg::HUE_W-1:0];
            high_limit = hi[abhcc_pkg::HUE_W-1:0];
         end
         over_half = (blue * abhcc_pkg::PERCENT_SCALE) / total > abhcc_pkg::HALF_PERCENT;
         if (over_half && half_blue_contours < HALF_COUNT_MAX) half_blue_contours++;

         // Exact integer compare, so a ratio above 100 can never be met.
         verdict.is_blue            = blue * abhcc_pkg::PERCENT_SCALE
                                      > int'(ratio_cfg) * total;
         verdict.over_half          = over_half;
         verdict.blue_points        = blue[abhcc_pkg::COUNT_W-1:0];
         verdict.point_total        = total[abhcc_pkg::COUNT_W-1:0];
         verdict.over_half_contours = half_blue_contours;
         verdict.low_hue_out        = low_limit;
         verdict.high_hue_out       = high_limit;
         awaited_verdicts.insert(awaited_verdicts.size(), verdict);

         blue_count   = '0;
         point_count  = '0;
         min_blue_hue = low_ceil_cfg;
         max_blue_hue = high_floor_cfg;
      end
   endtask

   // -------------------------------------------------------------------------
   // Point sender. Valid is only lowered during an idle gap, so a beat that
   // follows straight on keeps valid high without a glitch in between.
   // -------------------------------------------------------------------------
   task automatic send_point(input logic [abhcc_pkg::HUE_W-1:0] hue,
                             input logic [abhcc_pkg::SAT_W-1:0] sat,
                             input logic last_point);
      while ($urandom_range(99) < send_idle_pct) begin
         point_if.valid <= 1'b0;
         @(posedge clock);
      end
      point_if.valid      <= 1'b1;
      point_if.hue        <= hue;
      point_if.sat        <= sat;
      point_if.last_point <= last_point;
      do @(posedge clock); while (point_if.ready !== 1'b1);
      fold_point(hue, sat, last_point);
   endtask

   // One register write beat. The caller lowers valid after its last write.
   task automatic write_register(input abhcc_pkg::csr_idx_type index,
                                 input logic [abhcc_pkg::CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (index)
         abhcc_pkg::REG_SAT_MIN:       sat_min_cfg     = data;
         abhcc_pkg::REG_RATIO_PERCENT: ratio_cfg       = data[abhcc_pkg::RATIO_W-1:0];
         abhcc_pkg::REG_LOW_FLOOR:     low_floor_cfg   = data;
         abhcc_pkg::REG_LOW_CEIL:      low_ceil_cfg    = data;
         abhcc_pkg::REG_HIGH_FLOOR:    high_floor_cfg  = data;
         abhcc_pkg::REG_HIGH_CEIL:     high_ceil_cfg   = data;
         abhcc_pkg::REG_NEAR_MARGIN:   near_margin_cfg = data;
         abhcc_pkg::REG_FAR_MARGIN:    far_margin_cfg  = data;
         default: ;
      endcase
   endtask

   // Rewrite the whole register file. Only called with the block idle.
   task automatic set_window(input int sat_min, input int ratio, input int low_floor,
                             input int low_ceil, input int high_floor, input int high_ceil,
                             input int near_margin, input int far_margin);
      write_register(abhcc_pkg::REG_SAT_MIN, abhcc_pkg::CSR_DATA_W'(sat_min));
      write_register(abhcc_pkg::REG_RATIO_PERCENT, abhcc_pkg::CSR_DATA_W'(ratio));
      write_register(abhcc_pkg::REG_LOW_FLOOR, abhcc_pkg::CSR_DATA_W'(low_floor));
      write_register(abhcc_pkg::REG_LOW_CEIL, abhcc_pkg::CSR_DATA_W'(low_ceil));
      write_register(abhcc_pkg::REG_HIGH_FLOOR, abhcc_pkg::CSR_DATA_W'(high_floor));
      write_register(abhcc_pkg::REG_HIGH_CEIL, abhcc_pkg::CSR_DATA_W'(high_ceil));
      write_register(abhcc_pkg::REG_NEAR_MARGIN, abhcc_pkg::CSR_DATA_W'(near_margin));
      write_register(abhcc_pkg::REG_FAR_MARGIN, abhcc_pkg::CSR_DATA_W'(far_margin));
      csr_if.valid <= 1'b0;
   endtask

   // Stop offering points, wait for every predicted verdict, then let the
   // pipeline empty out behind any trailing non-closing points.
   task automatic drain_results();
      point_if.valid <= 1'b0;
      while (awaited_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A hue strictly inside the current window, so the point can count as blue; the low limit if none fits.
   function automatic logic [abhcc_pkg::HUE_W-1:0] pick_blue_hue();
      if (int'(high_limit) > int'(low_limit) + 1) begin
         return abhcc_pkg::HUE_W'($urandom_range(int'(low_limit) + 1,
                                                 int'(high_limit) - 1));
      end
      return low_limit;
   endfunction

   // Mostly hues in the window plus 3 on each side, with some from the full range.
   function automatic logic [abhcc_pkg::HUE_W-1:0] random_hue();
      int lo_band;
      int hi_band;
      lo_band = clamp_hue(int'(low_limit) - 3);
      hi_band = clamp_hue(int'(high_limit) + 3);
      if ($urandom_range(9) < 2) return abhcc_pkg::HUE_W'($urandom_range(HUE_MAX));
      return abhcc_pkg::HUE_W'($urandom_range(lo_band, hi_band));
   endfunction

   // Mostly saturations at or above the threshold, with some from the full range.
   function automatic logic [abhcc_pkg::SAT_W-1:0] random_sat();
      if ($urandom_range(9) < 3) return abhcc_pkg::SAT_W'($urandom_range(HUE_MAX));
      return abhcc_pkg::SAT_W'($urandom_range(int'(sat_min_cfg), HUE_MAX));
   endfunction

   task automatic send_random_contour(input int length);
      for (int i = 0; i < length; i++) begin
         send_point(random_hue(), random_sat(), i == length - 1);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result receiver and checker. Each accepted beat is matched against the
   // oldest predicted verdict; ready is then chosen for the next cycle.
   // -------------------------------------------------------------------------
   task automatic check_verdict();
      contour_verdict_type want;
      if (awaited_verdicts.size() == 0) begin
         flag_error("result beat arrived with no contour closed");
      end else begin
         want = awaited_verdicts.pop_front();
         check_field("is_blue", 32'(verdict_if.is_blue), 32'(want.is_blue));
         check_field("over_half", 32'(verdict_if.over_half), 32'(want.over_half));
         check_field("blue_points", 32'(verdict_if.blue_points),
                     32'(want.blue_points));
         check_field("point_total", 32'(verdict_if.point_total),
                     32'(want.point_total));
         check_field("over_half_contours", 32'(verdict_if.over_half_contours),
                     32'(want.over_half_contours));
         check_field("low_hue_out", 32'(verdict_if.low_hue_out),
                     32'(want.low_hue_out));
         check_field("high_hue_out", 32'(verdict_if.high_hue_out),
                     32'(want.high_hue_out));
      end
      verdicts_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         verdict_if.ready <= 1'b0;
      end else begin
         if (verdict_if.valid === 1'b1 && verdict_if.ready === 1'b1) check_verdict();
         // A requested long stall takes precedence over the random idling.
         if (backpressure_cycles > 0) begin
            backpressure_cycles--;
            verdict_if.ready <= 1'b0;
         end else begin
            verdict_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset register values. Points right on either hue limit, saturation
   // equal to the threshold and one above it, the field extremes, a single
   // point contour, and contours just above and at the blue count needed to
   // move the hue limits.
   task automatic test_window_boundaries();
      send_point(8'd120, 8'd255, 1'b0);
      send_point(8'd180, 8'd255, 1'b0);
      send_point(8'd121, 8'd101, 1'b0);
      send_point(8'd179, 8'd100, 1'b0);
      send_point(8'd0, 8'd0, 1'b0);
      send_point(8'd255, 8'd255, 1'b1);

      send_point(8'd150, 8'd255, 1'b1);

      send_point(8'd125, 8'd200, 1'b0);
      send_point(8'd130, 8'd200, 1'b0);
      send_point(8'd140, 8'd200, 1'b0);
      send_point(8'd150, 8'd200, 1'b0);
      send_point(8'd170, 8'd200, 1'b0);
      send_point(8'd178, 8'd200, 1'b1);

      repeat (5) send_point(8'd150, 8'd200, 1'b0);
      send_point(8'd150, 8'd50, 1'b1);
      drain_results();
   endtask

   // Ratio at zero, at a tie, at 100 and above 100, plus a saturation
   // threshold that no point can exceed.
   task automatic test_threshold_extremes();
      set_window(100, 0, 100, 140, 160, 200, 5, 10);
      send_point(8'd150, 8'd255, 1'b0);
      send_point(8'd10, 8'd255, 1'b1);
      send_point(8'd10, 8'd255, 1'b1);
      drain_results();

      set_window(100, 127, 100, 140, 160, 200, 5, 10);
      send_point(8'd150, 8'd255, 1'b0);
      send_point(8'd151, 8'd255, 1'b1);
      drain_results();

      // Exactly half blue: neither the ratio nor the over-half test passes.
      set_window(100, 50, 100, 140, 160, 200, 5, 10);
      send_point(8'd150, 8'd255, 1'b0);
      send_point(8'd10, 8'd255, 1'b1);
      drain_results();

      set_window(255, 100, 100, 140, 160, 200, 5, 10);
      send_point(8'd150, 8'd255, 1'b1);
      drain_results();
   endtask

   // A run of all-blue single point contours, each of which must advance the
   // over-half count by one.
   task automatic test_over_half_count();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_window(0, 12, 100, 140, 160, 200, 5, 10);
      repeat (30) send_point(pick_blue_hue(), 8'd255, 1'b1);
      drain_results();
   endtask

   // With both margins at their maximum, every adapting contour pushes the
   // low limit down and the high limit up by one step.
   task automatic test_hue_limit_widening();
      set_window(0, 12, 0, 255, 0, 255, 255, 255);
      repeat (20) begin
         for (int i = 0; i < 6; i++) send_point(pick_blue_hue(), 8'd255, i == 5);
      end
      drain_results();
   endtask

   // Random contours in three phases: the sender idling lightly and the
   // receiver heavily, then the reverse, then neither. The middle phase uses
   // extreme register values, the others random ones.
   task automatic test_random_traffic();
      int points_sent;
      int length;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 10;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 1) begin
            set_window(0, 100, 0, 0, 255, 255, 0, 0);
         end else begin
            set_window($urandom_range(0, 160), $urandom_range(0, 127),
                       $urandom_range(HUE_MAX), $urandom_range(HUE_MAX),
                       $urandom_range(HUE_MAX), $urandom_range(HUE_MAX),
                       $urandom_range(0, 40), $urandom_range(0, 40));
         end
         points_sent = 0;
         while (points_sent < 170) begin
            length = ($urandom_range(9) == 0) ? $urandom_range(13, 80)
                                              : $urandom_range(1, 12);
            send_random_contour(length);
            points_sent += length;
         end
         drain_results();
      end
   endtask

   // The receiver holds off for a long stretch while short contours keep
   // coming, so results back up and the block has to stop taking points.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_window(100, 12, 100, 140, 160, 200, 5, 10);
      backpressure_cycles = 300;
      repeat (40) send_random_contour($urandom_range(1, 4));
      drain_results();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      point_if.valid      <= 1'b0;
      point_if.hue        <= '0;
      point_if.sat        <= '0;
      point_if.last_point <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= abhcc_pkg::REG_SAT_MIN;
      csr_if.data         <= '0;

      // Predictor starts from the block's reset state.
      sat_min_cfg        = abhcc_pkg::SAT_MIN_RST;
      ratio_cfg          = abhcc_pkg::RATIO_PERCENT_RST;
      low_floor_cfg      = abhcc_pkg::LOW_FLOOR_RST;
      low_ceil_cfg       = abhcc_pkg::LOW_CEIL_RST;
      high_floor_cfg     = abhcc_pkg::HIGH_FLOOR_RST;
      high_ceil_cfg      = abhcc_pkg::HIGH_CEIL_RST;
      near_margin_cfg    = abhcc_pkg::NEAR_MARGIN_RST;
      far_margin_cfg     = abhcc_pkg::FAR_MARGIN_RST;
      low_limit          = abhcc_pkg::LOW_LIMIT_RST;
      high_limit         = abhcc_pkg::HIGH_LIMIT_RST;
      blue_count         = '0;
      point_count        = '0;
      min_blue_hue       = abhcc_pkg::LOW_CEIL_RST;
      max_blue_hue       = abhcc_pkg::HIGH_FLOOR_RST;
      half_blue_contours = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_window_boundaries();
      test_threshold_extremes();
      test_over_half_count();
      test_hue_limit_widening();
      test_random_traffic();
      test_output_backpressure();

      if (error_count == 0) begin
         $display("adaptive_blue_hue_contour_check verification clean");
      end else begin
         $display("adaptive_blue_hue_contour_check verification failed");
      end
      $finish;
   end

   // A hung handshake anywhere ends the run here.
   initial begin
      #(LIMIT_NS);
      $display("adaptive_blue_hue_contour_check verification failed");
      $finish;
   end

endmodule

/* sim.f */
design/abhcc_pkg.sv
design/abhcc_channels.sv
design/adaptive_blue_hue_contour_check.sv
tb/testbench.sv
